@@ design/gha_pkg.sv @@
// Shared types and codes for the generational handle allocator.
// No dependencies; imported by every design file.
package gha_pkg;

    // Operation codes
    localparam logic [2:0] OP_RESERVE     = 3'd0;
    localparam logic [2:0] OP_ASSIGN      = 3'd1;
    localparam logic [2:0] OP_MARK_DEAD   = 3'd2;
    localparam logic [2:0] OP_FREE        = 3'd3;
    localparam logic [2:0] OP_LOOK_ACTIVE = 3'd4;
    localparam logic [2:0] OP_LOOK_REMOVE = 3'd5;
    localparam logic [2:0] OP_RESET_ALL   = 3'd6;
    localparam logic [2:0] OP_UNUSED      = 3'd7;

    // Slot states
    localparam logic [1:0] SS_FREE     = 2'd0;
    localparam logic [1:0] SS_RESERVED = 2'd1;
    localparam logic [1:0] SS_IN_USE   = 2'd2;
    localparam logic [1:0] SS_DEAD     = 2'd3;

    // Result codes
    localparam logic [2:0] RC_OK            = 3'd0;
    localparam logic [2:0] RC_NO_MATCH      = 3'd1;
    localparam logic [2:0] RC_NO_FREE       = 3'd2;
    localparam logic [2:0] RC_IN_USE        = 3'd3;
    localparam logic [2:0] RC_NOT_PERMITTED = 3'd4;

    // Classified request passed from front to back
    typedef struct packed {
        logic        fixed;     // answer known up front, no table access
        logic [2:0]  fix_code;
        logic [2:0]  op;
        logic        cat;
        logic [8:0]  index;
        logic [15:0] gen;
    } gha_cmd_t;

    // One result item
    typedef struct packed {
        logic [2:0]  code;
        logic [8:0]  index;
        logic [15:0] gen;
        logic [1:0]  state;
    } gha_res_t;

endpackage

@@ design/gha_front.sv @@
// Front end: holds the server mode register, classifies requests and queues them.
// Depends on gha_pkg.
module gha_front #(
    parameter int BLOCK_SLOTS = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [2:0]        operation,
    input  logic              category,
    input  logic [8:0]        slot_index,
    input  logic [15:0]       generation_in,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              server_mode,
    input  logic              clearing,
    output logic              cmd_valid,
    output gha_pkg::gha_cmd_t cmd,
    input  logic              cmd_pop
);
    import gha_pkg::*;

    localparam int TABLE_SLOTS = 2 * BLOCK_SLOTS;

    logic       server_mode_reg;
    gha_cmd_t   q_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    gha_cmd_t   cls;
    logic       accept;

    // configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            server_mode_reg <= 1'b1;
        else if (cfg_valid)
            server_mode_reg <= server_mode;
    end

    // classify the incoming request
    always_comb
    begin
        cls.fixed    = 1'b0;
        cls.fix_code = RC_OK;
        cls.op       = operation;
        cls.cat      = category;
        cls.index    = slot_index;
        cls.gen      = generation_in;
        if (operation == OP_RESERVE)
        begin
            if (!category && !server_mode_reg)
            begin
                cls.fixed    = 1'b1;
                cls.fix_code = RC_NOT_PERMITTED;
                cls.index    = '0;
            end
        end
        else if (operation == OP_RESET_ALL)
        begin
            cls.fixed = 1'b0;
        end
        else if (operation == OP_UNUSED)
        begin
            cls.fixed    = 1'b1;
            cls.fix_code = RC_NOT_PERMITTED;
            cls.index    = '0;
        end
        else if (32'(slot_index) >= 32'(TABLE_SLOTS))
        begin
            cls.fixed    = 1'b1;
            cls.fix_code = RC_NO_MATCH;
        end
    end

    // two-entry request queue
    assign full      = (count_reg == 2'd2) || clearing;
    assign accept    = push && !full;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (accept)
            q_reg[wr_ptr_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (accept)
                wr_ptr_reg <= !wr_ptr_reg;
            if (cmd_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(accept) - 2'(cmd_pop);
        end
    end
endmodule

@@ design/gha_back.sv @@
// Back end: slot table memory, free bitmap and the execution sequencer.
// Depends on gha_pkg.
module gha_back #(
    parameter int BLOCK_SLOTS = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  gha_pkg::gha_cmd_t cmd,
    output logic              cmd_pop,
    output logic              clearing,
    input  logic              res_space,
    output logic              res_push,
    output gha_pkg::gha_res_t res
);
    import gha_pkg::*;

    localparam int TABLE_SLOTS = 2 * BLOCK_SLOTS;
    localparam int AW = $clog2(TABLE_SLOTS);
    localparam int OW = $clog2(BLOCK_SLOTS);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [17:0]            mem [TABLE_SLOTS];
    logic [17:0]            rd_data_reg;
    logic [1:0]             state_reg, state_next;
    logic [AW-1:0]          clr_cnt_reg;
    logic [AW-1:0]          addr_reg, addr_next;
    gha_cmd_t               cmd_reg;
    logic                   found_reg;
    logic [TABLE_SLOTS-1:0] free_reg, free_next;
    logic [BLOCK_SLOTS-1:0] blk;
    logic                   found;
    logic [OW-1:0]          off;
    logic                   we;
    logic [AW-1:0]          waddr;
    logic [17:0]            wdata;
    logic [1:0]             rd_st;
    logic [15:0]            rd_gen, inc_gen;
    logic                   hit;

    assign clearing = (state_reg == S_CLEAR);
    assign rd_st    = rd_data_reg[17:16];
    assign rd_gen   = rd_data_reg[15:0];

    // lowest free slot in the requested block
    assign blk = cmd.cat ? free_reg[TABLE_SLOTS-1:BLOCK_SLOTS] : free_reg[BLOCK_SLOTS-1:0];
    always_comb
    begin
        found = 1'b0;
        off   = '0;
        for (int i = BLOCK_SLOTS - 1; i >= 0; i--)
        begin
            if (blk[i])
            begin
                found = 1'b1;
                off   = OW'(i);
            end
        end
    end

    // issue: pick up a request and start the table read
    assign cmd_pop = (state_reg == S_IDLE) && cmd_valid && res_space;
    always_comb
    begin
        if (cmd.op == OP_RESERVE)
            addr_next = AW'(off) + (cmd.cat ? AW'(BLOCK_SLOTS) : AW'(0));
        else
            addr_next = AW'(cmd.index);
    end

    // sequencer: table clear sweep, then read-modify-write of one slot per request
    always_comb
    begin
        state_next = state_reg;
        free_next  = free_reg;
        we         = 1'b0;
        waddr      = addr_reg;
        wdata      = rd_data_reg;
        res_push   = 1'b0;
        res        = '0;
        inc_gen    = 16'(rd_gen + 16'd1);
        if (inc_gen == 16'd0)
            inc_gen = 16'd1;
        hit = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_cnt_reg;
                wdata = {SS_FREE, 16'd1};
                if (clr_cnt_reg == AW'(TABLE_SLOTS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (cmd_pop)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                res_push   = 1'b1;
                state_next = S_IDLE;
                res.index  = cmd_reg.index;
                if (cmd_reg.fixed)
                begin
                    res.code = cmd_reg.fix_code;
                end
                else
                begin
                    case (cmd_reg.op)
                        OP_RESERVE:
                        begin
                            if (found_reg)
                            begin
                                we    = 1'b1;
                                wdata = {SS_RESERVED, rd_gen};
                                free_next[addr_reg] = 1'b0;
                                res = '{RC_OK, 9'(addr_reg), rd_gen, SS_RESERVED};
                            end
                            else
                                res = '{RC_NO_FREE, 9'd0, 16'd0, SS_FREE};
                        end
                        OP_ASSIGN:
                        begin
                            if (rd_st == SS_IN_USE)
                                res = '{RC_IN_USE, cmd_reg.index, rd_gen, SS_IN_USE};
                            else
                            begin
                                we    = 1'b1;
                                wdata = {SS_IN_USE, cmd_reg.gen};
                                free_next[addr_reg] = 1'b0;
                                res = '{RC_OK, cmd_reg.index, cmd_reg.gen, SS_IN_USE};
                            end
                        end
                        OP_MARK_DEAD:
                        begin
                            we    = 1'b1;
                            wdata = {SS_DEAD, rd_gen};
                            free_next[addr_reg] = 1'b0;
                            res = '{RC_OK, cmd_reg.index, rd_gen, SS_DEAD};
                        end
                        OP_FREE:
                        begin
                            we    = 1'b1;
                            wdata = {SS_FREE, inc_gen};
                            free_next[addr_reg] = 1'b1;
                            res = '{RC_OK, cmd_reg.index, inc_gen, SS_FREE};
                        end
                        OP_LOOK_ACTIVE:
                        begin
                            hit = (rd_st == SS_IN_USE) && (rd_gen == cmd_reg.gen);
                            res = '{hit ? RC_OK : RC_NO_MATCH, cmd_reg.index, rd_gen, rd_st};
                        end
                        OP_RESET_ALL:
                        begin
                            free_next  = '1;
                            state_next = S_CLEAR;
                            res = '{RC_OK, 9'd0, 16'd1, SS_FREE};
                        end
                        default:
                        begin
                            hit = (rd_gen == cmd_reg.gen);
                            res = '{hit ? RC_OK : RC_NO_MATCH, cmd_reg.index, rd_gen, rd_st};
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // slot table: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_data_reg <= mem[addr_next];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg   <= cmd;
            addr_reg  <= addr_next;
            found_reg <= found;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            free_reg    <= '1;
        end
        else
        begin
            state_reg <= state_next;
            free_reg  <= free_next;
            if (state_reg == S_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            else
                clr_cnt_reg <= '0;
        end
    end
endmodule

@@ design/gha_resq.sv @@
// Two-entry result queue facing the consumer.
// Depends on gha_pkg.
module gha_resq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_push,
    input  gha_pkg::gha_res_t res,
    output logic              res_space,
    output logic              empty,
    input  logic              pop,
    output gha_pkg::gha_res_t head
);
    import gha_pkg::*;

    gha_res_t   q_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       deq;

    assign empty     = (count_reg == 2'd0);
    assign res_space = (count_reg != 2'd2);
    assign deq       = pop && !empty;
    assign head      = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (res_push)
            q_reg[wr_ptr_reg] <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (res_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (deq)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(res_push) - 2'(deq);
        end
    end
endmodule

@@ design/generational_handle_allocator.sv @@
// Generational handle allocator (slot map), top level.
// Depends on gha_pkg, gha_front, gha_back, gha_resq.
//
// Usage: requests enter through a queue-style port (push/full, accepted when
// push is high and full low); results leave through a queue-style port
// (empty/pop, the head is valid while empty is low). server_mode is written on
// its own channel (cfg_valid/cfg_ready, ready always high); the user must
// write it only while idle, which the block does not enforce. Each request
// yields exactly one result, in order. Flow: a request accepted while the block
// is idle is issued from the request queue with the slot table read and the
// free-slot search; the execute state then writes the slot back and queues the
// result. No new request is issued until that read-modify-write is done.
// Reset: server_mode becomes 1 and the table is swept to free, generation 1,
// one slot per cycle; full stays high meanwhile. A reset-all request runs the
// same sweep after its result is queued.
// Stalls: the request and result queues hold two entries each; when the
// consumer stops popping, execution pauses and full rises once the request
// queue fills. Nothing is lost or repeated.
module generational_handle_allocator #(
    parameter int BLOCK_SLOTS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  operation,
    input  logic        category,
    input  logic [8:0]  slot_index,
    input  logic [15:0] generation_in,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  result_code,
    output logic [8:0]  handle_index,
    output logic [15:0] handle_generation,
    output logic [1:0]  slot_state_out,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        server_mode
);
    import gha_pkg::*;

    gha_cmd_t cmd;
    gha_res_t res, head;
    logic     cmd_valid, cmd_pop, clearing, res_space, res_push;

    gha_front #(.BLOCK_SLOTS(BLOCK_SLOTS)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .operation(operation), .category(category), .slot_index(slot_index),
        .generation_in(generation_in), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .server_mode(server_mode), .clearing(clearing),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
    );

    gha_back #(.BLOCK_SLOTS(BLOCK_SLOTS)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd),
        .cmd_pop(cmd_pop), .clearing(clearing), .res_space(res_space),
        .res_push(res_push), .res(res)
    );

    gha_resq u_resq (
        .clk(clk), .rst_n(rst_n), .res_push(res_push), .res(res),
        .res_space(res_space), .empty(empty), .pop(pop), .head(head)
    );

    assign result_code       = head.code;
    assign handle_index      = head.index;
    assign handle_generation = head.gen;
    assign slot_state_out    = head.state;
endmodule

@@ verif/generational_handle_allocator_tb.sv @@
// Self-checking testbench for generational_handle_allocator.
// Depends on gha_pkg and the design files; keeps its own slot table mirror.
module generational_handle_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gha_pkg::*;

    localparam int BLOCK_SLOTS = 256;
    localparam int TABLE_SLOTS = 2 * BLOCK_SLOTS;
    localparam int SETTLE_CYCLES = TABLE_SLOTS + 20;

    typedef struct {
        logic [2:0]  op;
        logic        cat;
        logic [8:0]  idx;
        logic [15:0] gen;
    } slot_req_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [2:0]  operation;
    logic        category;
    logic [8:0]  slot_index;
    logic [15:0] generation_in;
    logic        empty;
    logic        pop;
    logic [2:0]  result_code;
    logic [8:0]  handle_index;
    logic [15:0] handle_generation;
    logic [1:0]  slot_state_out;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        server_mode;

    generational_handle_allocator #(.BLOCK_SLOTS(BLOCK_SLOTS)) dut (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full),
        .operation(operation), .category(category),
        .slot_index(slot_index), .generation_in(generation_in),
        .empty(empty), .pop(pop),
        .result_code(result_code), .handle_index(handle_index),
        .handle_generation(handle_generation), .slot_state_out(slot_state_out),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .server_mode(server_mode)
    );

    // Mirror of the slot table and the server flag
    logic [1:0]  mir_state [TABLE_SLOTS];
    logic [15:0] mir_gen [TABLE_SLOTS];
    logic        mir_server;

    slot_req_t   pending_reqs[$];
    gha_res_t    results_due[$];
    slot_req_t   cur_req;
    int          send_gap;
    int          recv_gap;
    bit          calm;
    int          mismatches;
    bit          failed;

    always #5 clk = ~clk;

    function automatic void clear_mirror();
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            mir_state[i] = SS_FREE;
            mir_gen[i] = 16'd1;
        end
    endfunction

    // Apply one request to the mirror and return the result it should give
    function automatic gha_res_t apply_request(slot_req_t r);
        gha_res_t    res;
        int          first;
        logic [15:0] g;
        res = '0;
        if (r.op == OP_RESERVE)
        begin
            if (!r.cat && !mir_server)
            begin
                res.code = RC_NOT_PERMITTED;
                return res;
            end
            first = r.cat ? BLOCK_SLOTS : 0;
            for (int i = first; i < first + BLOCK_SLOTS; i++)
            begin
                if (mir_state[i] == SS_FREE)
                begin
                    mir_state[i] = SS_RESERVED;
                    res.code = RC_OK;
                    res.index = i[8:0];
                    res.gen = mir_gen[i];
                    res.state = SS_RESERVED;
                    return res;
                end
            end
            res.code = RC_NO_FREE;
            return res;
        end
        if (r.op == OP_RESET_ALL)
        begin
            clear_mirror();
            res.code = RC_OK;
            res.gen = 16'd1;
            res.state = SS_FREE;
            return res;
        end
        if (r.op == OP_UNUSED)
        begin
            res.code = RC_NOT_PERMITTED;
            return res;
        end
        if (int'(r.idx) >= TABLE_SLOTS)
        begin
            res.code = RC_NO_MATCH;
            res.index = r.idx;
            return res;
        end
        res.index = r.idx;
        case (r.op)
            OP_ASSIGN:
            begin
                if (mir_state[r.idx] == SS_IN_USE)
                    res.code = RC_IN_USE;
                else
                begin
                    mir_gen[r.idx] = r.gen;
                    mir_state[r.idx] = SS_IN_USE;
                    res.code = RC_OK;
                end
            end
            OP_MARK_DEAD:
            begin
                mir_state[r.idx] = SS_DEAD;
                res.code = RC_OK;
            end
            OP_FREE:
            begin
                g = mir_gen[r.idx] + 16'd1;
                if (g == 16'd0)
                    g = 16'd1;
                mir_gen[r.idx] = g;
                mir_state[r.idx] = SS_FREE;
                res.code = RC_OK;
            end
            OP_LOOK_ACTIVE:
                res.code = (mir_state[r.idx] == SS_IN_USE && mir_gen[r.idx] == r.gen)
                           ? RC_OK : RC_NO_MATCH;
            default:
                res.code = (mir_gen[r.idx] == r.gen) ? RC_OK : RC_NO_MATCH;
        endcase
        res.gen = mir_gen[r.idx];
        res.state = mir_state[r.idx];
        return res;
    endfunction

    function automatic slot_req_t mk_req(logic [2:0] op, logic cat, logic [8:0] idx,
                                         logic [15:0] gen);
        slot_req_t r;
        r.op = op;
        r.cat = cat;
        r.idx = idx;
        r.gen = gen;
        return r;
    endfunction

    // Random request, mostly aimed at a small window of slots in each block
    function automatic slot_req_t random_req();
        slot_req_t r;
        int        pick;
        r.cat = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 30)
            r.op = OP_RESERVE;
        else if (pick < 45)
            r.op = OP_ASSIGN;
        else if (pick < 53)
            r.op = OP_MARK_DEAD;
        else if (pick < 68)
            r.op = OP_FREE;
        else if (pick < 82)
            r.op = OP_LOOK_ACTIVE;
        else if (pick < 96)
            r.op = OP_LOOK_REMOVE;
        else if (pick < 98)
            r.op = OP_UNUSED;
        else
            r.op = OP_RESET_ALL;
        if ($urandom_range(0, 9) == 0)
            r.idx = 9'($urandom_range(0, TABLE_SLOTS - 1));
        else
            r.idx = 9'((r.cat ? BLOCK_SLOTS : 0) + $urandom_range(0, 11));
        pick = $urandom_range(0, 9);
        if (pick < 6)
            r.gen = mir_gen[r.idx];
        else if (pick == 6)
            r.gen = 16'hFFFF;
        else if (pick == 7)
            r.gen = 16'h0000;
        else
            r.gen = 16'($urandom_range(0, 65535));
        return r;
    endfunction

    // Request driver
    always @(posedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
                results_due.push_back(apply_request(cur_req));
            if (push && full)
            begin
                // hold the request until taken
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                push <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 11) == 0)
            begin
                send_gap = $urandom_range(0, 17);
                push <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                cur_req = pending_reqs.pop_front();
                push <= 1'b1;
                operation <= cur_req.op;
                category <= cur_req.cat;
                slot_index <= cur_req.idx;
                generation_in <= cur_req.gen;
            end
            else
                push <= 1'b0;
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        gha_res_t want;
        gha_res_t got;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                got = '{result_code, handle_index, handle_generation, slot_state_out};
                if (results_due.size() == 0)
                begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with none expected: %p", $realtime, got);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (got !== want)
                    begin
                        failed = 1'b1;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch code %0d/%0d idx %0d/%0d gen %h/%h st %0d/%0d",
                                     $realtime, want.code, got.code, want.index, got.index,
                                     want.gen, got.gen, want.state, got.state);
                    end
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                pop <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 11) == 0)
            begin
                recv_gap = $urandom_range(0, 17);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // Wait until every request has been answered and the table has settled
    task automatic drain();
        do
            @(posedge clk);
        while (pending_reqs.size() > 0 || push || results_due.size() > 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_server(logic val);
        cfg_valid <= 1'b1;
        server_mode <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        mir_server = val;
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
            pending_reqs.push_back(random_req());
    endtask

    // Timeout
    initial
    begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        operation = OP_RESERVE;
        category = 1'b0;
        slot_index = '0;
        generation_in = '0;
        cfg_valid = 1'b0;
        server_mode = 1'b1;
        send_gap = 0;
        recv_gap = 0;
        calm = 1'b0;
        mismatches = 0;
        failed = 1'b0;
        mir_server = 1'b1;
        clear_mirror();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: every operation, wrap of the generation, boundary indexes
        pending_reqs.push_back(mk_req(OP_RESERVE, 1'b0, 9'd0, 16'd0));
        pending_reqs.push_back(mk_req(OP_RESERVE, 1'b1, 9'd0, 16'd0));
        pending_reqs.push_back(mk_req(OP_ASSIGN, 1'b0, 9'd0, 16'hFFFF));
        pending_reqs.push_back(mk_req(OP_ASSIGN, 1'b0, 9'd0, 16'h1234));
        pending_reqs.push_back(mk_req(OP_LOOK_ACTIVE, 1'b0, 9'd0, 16'hFFFF));
        pending_reqs.push_back(mk_req(OP_LOOK_ACTIVE, 1'b0, 9'd0, 16'h1234));
        pending_reqs.push_back(mk_req(OP_LOOK_REMOVE, 1'b0, 9'd0, 16'hFFFF));
        pending_reqs.push_back(mk_req(OP_FREE, 1'b0, 9'd0, 16'd0));
        pending_reqs.push_back(mk_req(OP_LOOK_REMOVE, 1'b0, 9'd0, 16'd1));
        pending_reqs.push_back(mk_req(OP_ASSIGN, 1'b1, 9'd511, 16'd0));
        pending_reqs.push_back(mk_req(OP_LOOK_ACTIVE, 1'b1, 9'd511, 16'd0));
        pending_reqs.push_back(mk_req(OP_MARK_DEAD, 1'b1, 9'd511, 16'h5555));
        pending_reqs.push_back(mk_req(OP_LOOK_ACTIVE, 1'b1, 9'd511, 16'd0));
        pending_reqs.push_back(mk_req(OP_LOOK_REMOVE, 1'b1, 9'd511, 16'd0));
        pending_reqs.push_back(mk_req(OP_MARK_DEAD, 1'b0, 9'd255, 16'd0));
        pending_reqs.push_back(mk_req(OP_FREE, 1'b0, 9'd256, 16'd0));
        pending_reqs.push_back(mk_req(OP_UNUSED, 1'b1, 9'd3, 16'hAAAA));
        pending_reqs.push_back(mk_req(OP_RESET_ALL, 1'b0, 9'd0, 16'd0));
        pending_reqs.push_back(mk_req(OP_LOOK_REMOVE, 1'b1, 9'd511, 16'd1));
        drain();

        // Client mode: replicated reserves are refused
        write_server(1'b0);
        pending_reqs.push_back(mk_req(OP_RESERVE, 1'b0, 9'd0, 16'd0));
        queue_random(300);
        drain();

        // Server mode: fill the local block until it runs out, then random
        write_server(1'b1);
        for (int i = 0; i < BLOCK_SLOTS + 4; i++)
            pending_reqs.push_back(mk_req(OP_RESERVE, 1'b1, 9'd0, 16'd0));
        pending_reqs.push_back(mk_req(OP_FREE, 1'b1, 9'd300, 16'd0));
        pending_reqs.push_back(mk_req(OP_RESERVE, 1'b1, 9'd0, 16'd0));
        queue_random(200);
        drain();

        write_server(1'b0);
        queue_random(200);
        drain();

        // Final stretch: random gaps until under 60 requests remain, then both sides at full rate
        write_server(1'b1);
        queue_random(250);
        wait (pending_reqs.size() < 60);
        calm = 1'b1;
        drain();

        if (!failed && results_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ generational_handle_allocator.f @@
design/gha_pkg.sv
design/gha_front.sv
design/gha_back.sv
design/gha_resq.sv
design/generational_handle_allocator.sv
verif/generational_handle_allocator_tb.sv
